### design/lmg_pkg.sv
// Shared types and constants for the multistream Lehmer generator.
`timescale 1ns / 1ps

package lmg_pkg;

   localparam int VALUE_W  = 31;
   localparam int STREAM_W = 4;
   localparam int CNT_W    = 33;

   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_RESEED = 1'b1;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]   count_type;

   localparam value_type LEHMER_P  = 31'h7FFF_FFFF;
   localparam value_type LEHMER_A  = 31'd16807;
   localparam count_type SEED_STEP = 33'd1000000;

   typedef struct packed {
      logic      start;
      value_type a;
      value_type b;
   } mul_req_type;

   typedef struct packed {
      logic      done;
      value_type value;
   } mul_rsp_type;

endpackage

### design/lmg_mulmod.sv
// Shared modular multiplier, modulus 2^31-1.
`timescale 1ns / 1ps

module lmg_mulmod
   import lmg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [2*VALUE_W-1:0] prod_ff;
   logic                 stage_ff;
   logic                 done_ff;
   value_type            res_ff;

   logic [VALUE_W:0] fold1;
   logic [VALUE_W:0] fold2;
   value_type        res_in;

   // Mersenne fold twice, then one conditional subtract
   always_comb begin
      fold1 = {1'b0, prod_ff[VALUE_W-1:0]} + {1'b0, prod_ff[2*VALUE_W-1:VALUE_W]};
      fold2 = {1'b0, fold1[VALUE_W-1:0]} + {{VALUE_W{1'b0}}, fold1[VALUE_W]};
      if (fold2 >= {1'b0, LEHMER_P}) begin
         res_in = VALUE_W'(fold2 - {1'b0, LEHMER_P});
      end else begin
         res_in = fold2[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= req.start;
         done_ff  <= stage_ff;
      end
      if (req.start) begin
         prod_ff <= req.a * req.b;
      end
      if (stage_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

### design/lmg_state_mem.sv
// Stream state memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module lmg_state_mem
   import lmg_pkg::*;
#(
   parameter int NUM_STREAMS = 15
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [((NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1)-1:0] rd_addr,
   output value_type                                     rd_data,
   input  logic                                          wr_en,
   input  logic [((NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1)-1:0] wr_addr,
   input  value_type                                     wr_data
);

   value_type              mem_ff [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] valid_ff;
   value_type              rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten entries read as the reset value, zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### design/multistream_lehmer_generator.sv
// Multistream Lehmer generator: sequencer around one shared modular multiplier.
// Draw: one modular product, then write-back and strobe; next start taken in idle;
//   a draw on an out-of-range stream answers in the next cycle and stays ready.
// Reseed: per stream one square-and-multiply pass over the advance count, at most
//   65 modular products and one write per stream. Results are one-cycle strobes,
//   no backpressure.
// Synchronous reset clears all streams to zero and returns the sequencer to idle.
`timescale 1ns / 1ps

module multistream_lehmer_generator
   import lmg_pkg::*;
#(
   parameter int NUM_STREAMS = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [STREAM_W-1:0] req_stream,
   input  logic [VALUE_W-1:0]  req_seed_value,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_reseeded
);

   localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam logic [AW-1:0] LAST_K = AW'(NUM_STREAMS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW_MUL,
      ST_DRAW_WAIT,
      ST_SEED_STEP,
      ST_SEED_MR,
      ST_SEED_SQ
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] draw_addr_ff, draw_addr_in;
   count_type     n_ff, n_in;
   count_type     e_ff, e_in;
   count_type     inc_ff, inc_in;
   value_type     base_ff, base_in;
   value_type     r_ff, r_in;
   value_type     b_ff, b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_value_ff, rsp_value_in;
   logic          rsp_reseeded_ff, rsp_reseeded_in;

   mul_req_type   mul_req;
   mul_rsp_type   mul_rsp;
   logic [AW-1:0] rd_addr;
   value_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   value_type     wr_data;

   logic [AW+STREAM_W-1:0] idx_ext;
   logic                   idx_ok;
   value_type              seed_base;
   count_type              n_next;

   lmg_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   lmg_state_mem #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign idx_ext   = {{AW{1'b0}}, req_stream};
   assign idx_ok    = (32'(req_stream) < NUM_STREAMS);
   assign seed_base = (req_seed_value == LEHMER_P) ? '0 : req_seed_value;
   assign n_next    = n_ff + inc_ff;
   assign rd_addr   = idx_ok ? idx_ext[AW-1:0] : '0;

   always_comb begin
      state_in        = state_ff;
      k_in            = k_ff;
      draw_addr_in    = draw_addr_ff;
      n_in            = n_ff;
      e_in            = e_ff;
      inc_in          = inc_ff;
      base_in         = base_ff;
      r_in            = r_ff;
      b_in            = b_ff;
      rsp_valid_in    = 1'b0;
      rsp_value_in    = rsp_value_ff;
      rsp_reseeded_in = rsp_reseeded_ff;
      mul_req         = '0;
      wr_en           = 1'b0;
      wr_addr         = k_ff;
      wr_data         = r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_DRAW) begin
                  if (idx_ok) begin
                     draw_addr_in = idx_ext[AW-1:0];
                     state_in     = ST_DRAW_MUL;
                  end else begin
                     rsp_valid_in    = 1'b1;
                     rsp_value_in    = '0;
                     rsp_reseeded_in = 1'b0;
                  end
               end else begin
                  base_in  = seed_base;
                  r_in     = seed_base;
                  b_in     = LEHMER_A;
                  n_in     = {2'b00, req_seed_value};
                  e_in     = {2'b00, req_seed_value};
                  inc_in   = SEED_STEP;
                  k_in     = '0;
                  state_in = ST_SEED_STEP;
               end
            end
         end
         ST_DRAW_MUL: begin
            mul_req.start = 1'b1;
            mul_req.a     = LEHMER_A;
            mul_req.b     = rd_data;
            state_in      = ST_DRAW_WAIT;
         end
         ST_DRAW_WAIT: begin
            if (mul_rsp.done) begin
               wr_en           = 1'b1;
               wr_addr         = draw_addr_ff;
               wr_data         = mul_rsp.value;
               rsp_valid_in    = 1'b1;
               rsp_value_in    = mul_rsp.value;
               rsp_reseeded_in = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         ST_SEED_STEP: begin
            if (e_ff == '0) begin
               wr_en = 1'b1;
               if (k_ff == LAST_K) begin
                  rsp_valid_in    = 1'b1;
                  rsp_value_in    = '0;
                  rsp_reseeded_in = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  k_in   = k_ff + 1'b1;
                  n_in   = n_next;
                  e_in   = n_next;
                  inc_in = inc_ff + SEED_STEP;
                  r_in   = base_ff;
                  b_in   = LEHMER_A;
               end
            end else if (e_ff[0]) begin
               mul_req.start = 1'b1;
               mul_req.a     = r_ff;
               mul_req.b     = b_ff;
               state_in      = ST_SEED_MR;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = b_ff;
               mul_req.b     = b_ff;
               state_in      = ST_SEED_SQ;
            end
         end
         ST_SEED_MR: begin
            if (mul_rsp.done) begin
               r_in     = mul_rsp.value;
               e_in     = {e_ff[CNT_W-1:1], 1'b0};
               state_in = ST_SEED_STEP;
            end
         end
         ST_SEED_SQ: begin
            if (mul_rsp.done) begin
               b_in     = mul_rsp.value;
               e_in     = {1'b0, e_ff[CNT_W-1:1]};
               state_in = ST_SEED_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff            <= k_in;
      draw_addr_ff    <= draw_addr_in;
      n_ff            <= n_in;
      e_ff            <= e_in;
      inc_ff          <= inc_in;
      base_ff         <= base_in;
      r_ff            <= r_in;
      b_ff            <= b_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_reseeded_ff <= rsp_reseeded_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_reseeded = rsp_reseeded_ff;

   a_fell_busy_responds: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("sequencer left busy without a result beat");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_DRAW_WAIT || state_ff == ST_SEED_MR ||
                        state_ff == ST_SEED_SQ))
      else $error("multiplier result arrived with no consumer");

   a_value_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value != LEHMER_P))
      else $error("result beat not reduced modulo p");

   a_no_mul_overlap: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |=> !mul_req.start)
      else $error("multiplier issued on consecutive cycles");

endmodule
